[design/pmt_pkg.sv]
// Shared types and constants for the PMT section parser.
package pmt_pkg;

    // Parser phase within one section
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SKIP,
        PH_ENTRY,
        PH_DONE
    } phase_t;

    // Result kind carried on tuser
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_ENTRY  = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    localparam logic [12:0] OFS_MAX         = 13'd8191;
    localparam logic [9:0]  COUNT_MAX       = 10'd1023;
    localparam logic [11:0] ENTRY_BYTES     = 12'd5;
    localparam logic [12:0] OFS_TABLE_ID    = 13'd0;
    localparam logic [12:0] OFS_LEN_HI      = 13'd1;
    localparam logic [12:0] OFS_LEN_LO      = 13'd2;
    localparam logic [12:0] OFS_PCR_LAST    = 13'd9;
    localparam logic [12:0] OFS_PINFO_HI    = 13'd10;

    // One result item; hdr holds the packed header fields
    typedef struct packed {
        kind_t       kind;
        logic [63:0] hdr;
        logic [7:0]  stream_kind;
        logic [12:0] stream_pid;
        logic [9:0]  stream_count;
        logic        last;
    } result_t;

    // Results produced by one accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

[design/pmt_parse.sv]
// Byte-wise PMT section state machine producing up to two results per byte.
module pmt_parse
    import pmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       section_start,
    output push_t      push
);

    phase_t      phase_reg, phase_next;
    logic [12:0] ofs_reg, ofs_next;
    logic [11:0] end_reg, end_next;
    logic [11:0] skip_reg, skip_next;
    logic [31:0] acc_reg, acc_next;
    logic [63:0] hdr_reg, hdr_next;
    logic [9:0]  ent_reg, ent_next;

    phase_t      ph;
    logic [12:0] ofs;
    logic [11:0] skip_cur;
    logic [31:0] acc_cur;
    logic [39:0] full;
    logic [11:0] len;
    logic [11:0] skip_dec;
    logic        do_bnd;
    logic        end_emit;
    result_t     res;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ofs_reg   <= '0;
            end_reg   <= '0;
            skip_reg  <= '0;
            acc_reg   <= '0;
            hdr_reg   <= '0;
            ent_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ofs_reg   <= ofs_next;
            end_reg   <= end_next;
            skip_reg  <= skip_next;
            acc_reg   <= acc_next;
            hdr_reg   <= hdr_next;
            ent_reg   <= ent_next;
        end
    end

    // Next state and results for one byte
    always_comb
    begin
        phase_next = phase_reg;
        ofs_next   = ofs_reg;
        end_next   = end_reg;
        skip_next  = skip_reg;
        acc_next   = acc_reg;
        hdr_next   = hdr_reg;
        ent_next   = ent_reg;
        push       = '0;
        do_bnd     = 1'b0;
        end_emit   = 1'b0;
        len        = '0;
        full       = '0;
        skip_dec   = '0;
        res        = '0;
        ph         = phase_reg;
        ofs        = ofs_reg;
        skip_cur   = skip_reg;
        acc_cur    = acc_reg;

        if (accept)
        begin
            // A start byte abandons any section in progress
            if (section_start)
            begin
                ph        = PH_HEADER;
                ofs       = '0;
                skip_cur  = '0;
                acc_cur   = '0;
                end_next  = '0;
                hdr_next  = '0;
                ent_next  = '0;
                phase_next = PH_HEADER;
                skip_next = '0;
                acc_next  = '0;
            end

            if (ph != PH_IDLE && ph != PH_DONE)
            begin
                ofs_next = (ofs == OFS_MAX) ? ofs : ofs + 13'd1;
                skip_dec = (skip_cur == '0) ? skip_cur : skip_cur - 12'd1;
                full     = {acc_cur, data_byte};

                case (ph)
                    PH_HEADER:
                    begin
                        if (ofs == OFS_TABLE_ID)
                            hdr_next = {56'd0, data_byte};
                        else if (ofs == OFS_LEN_HI || ofs == OFS_PINFO_HI)
                            acc_next = {24'd0, data_byte};
                        else if (ofs == OFS_LEN_LO)
                        begin
                            len      = {acc_cur[3:0], data_byte};
                            end_next = (len == '0) ? '0 : len - 12'd1;
                        end
                        else if (ofs <= OFS_PCR_LAST)
                            hdr_next = {hdr_next[55:0], data_byte};
                        else
                        begin
                            // Program info length: emit the header result
                            len           = {acc_cur[3:0], data_byte};
                            acc_next      = '0;
                            push.cnt      = 2'd1;
                            push.r0       = '0;
                            push.r0.kind  = KIND_HEADER;
                            push.r0.hdr   = hdr_next;
                            push.r0.stream_count = ent_next;
                            if (len == '0)
                                do_bnd = 1'b1;
                            else
                            begin
                                skip_next  = len;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == '0)
                            do_bnd = 1'b1;
                    end
                    PH_ENTRY:
                    begin
                        acc_next  = full[31:0];
                        skip_next = skip_dec;
                        if (skip_dec == '0)
                        begin
                            // Entry complete: emit stream type and PID
                            if (ent_next != COUNT_MAX)
                                ent_next = ent_next + 10'd1;
                            push.cnt              = 2'd1;
                            push.r0               = '0;
                            push.r0.kind          = KIND_ENTRY;
                            push.r0.hdr           = hdr_next;
                            push.r0.stream_kind   = full[39:32];
                            push.r0.stream_pid    = full[28:16];
                            push.r0.stream_count  = ent_next;
                            acc_next              = '0;
                            if (full[11:0] == '0)
                                do_bnd = 1'b1;
                            else
                            begin
                                skip_next  = full[11:0];
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = ph;
                    end
                endcase

                // Entry boundary: end the list or start a new entry
                if (do_bnd)
                begin
                    if (ofs_next >= {1'b0, end_next})
                    begin
                        res              = '0;
                        res.kind         = KIND_END;
                        res.hdr          = hdr_next;
                        res.stream_count = ent_next;
                        end_emit         = 1'b1;
                        phase_next       = PH_DONE;
                        if (push.cnt == 2'd0)
                        begin
                            push.r0  = res;
                            push.cnt = 2'd1;
                        end
                        else
                        begin
                            push.r1  = res;
                            push.cnt = 2'd2;
                        end
                    end
                    else
                    begin
                        phase_next = PH_ENTRY;
                        skip_next  = ENTRY_BYTES;
                        acc_next   = '0;
                    end
                end

                // Mark the final result of this byte
                if (push.cnt == 2'd2)
                    push.r1.last = 1'b1;
                else if (push.cnt == 2'd1)
                    push.r0.last = 1'b1;
            end
        end
    end

    // A second result in one byte is always the end of the list
    a_two_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> push.r1.kind == KIND_END)
        else $error("second result of a byte is not an end result");

    // An end result leaves the parser done
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        end_emit |=> phase_reg == PH_DONE)
        else $error("parser not done after end result");

    // Idle bytes without a start produce nothing
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !section_start && (phase_reg == PH_IDLE || phase_reg == PH_DONE))
        |-> push.cnt == 2'd0)
        else $error("result produced outside a section");

endmodule

[design/pmt_outq.sv]
// Small result queue taking up to two results per cycle and draining one while out_ready is high.
module pmt_outq
    import pmt_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_ROOM = CW'(DEPTH - 2);

    result_t       mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next, wr_plus;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_res   = mem_reg[rd_reg];
    assign room      = (cnt_reg <= CNT_ROOM);
    assign wr_plus   = ptr_inc(wr_reg);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(push.cnt) - CW'(pop);
        if (push.cnt == 2'd1)
            wr_next = wr_plus;
        else if (push.cnt == 2'd2)
            wr_next = ptr_inc(wr_plus);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[wr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            mem_reg[wr_plus] <= push.r1;
    end

    // Occupancy never exceeds the queue depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("result queue overflow");

endmodule

[design/ts_pmt_section_parser.sv]
// Top level of the MPEG-TS program map section parser.
// Section bytes enter one per cycle on the slave stream; tuser marks the table id byte
// that starts a section. Each byte is parsed in the cycle it is transferred, and its
// results (at most two: a header or stream entry, then possibly the end of the stream
// list) are written into a small output queue of OUT_DEPTH entries that drains one
// result per cycle while m_tready is high. Input throughput is one byte per cycle;
// tready drops only while the queue has fewer than two free slots, which happens only
// when the output side stalls, since a byte with two results always ends the list and
// the bytes that follow it add none. Results carry the header fields on every kind; the
// CRC is not checked and bytes after the stream list are dropped until the next section
// start.
module ts_pmt_section_parser
    import pmt_pkg::*;
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // section_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // tbl_id[7:0], prog_num[23:8], ver_num[28:24], current_next[29],
    // section_index[37:30], last_section_index[45:38], clock_ref_pid[58:46],
    // stream_kind[66:59], stream_pid[79:67], stream_count[89:80], zero fill[95:90]
    output logic [95:0] m_tdata,
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    push_t   push;
    result_t res;
    logic    room;
    logic    accept;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    pmt_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_tdata),
        .section_start (s_tuser),
        .push          (push)
    );

    pmt_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result onto the master stream
    assign m_tdata = {6'd0, res.stream_count, res.stream_pid, res.stream_kind,
                      res.hdr[12:0], res.hdr[23:16], res.hdr[31:24], res.hdr[32],
                      res.hdr[37:33], res.hdr[55:40], res.hdr[63:56]};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
